// ----- sv/rbfk_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbfk_pkg - shared definitions for the RBF kernel entry unit
// Field widths, fixed-point constants, register indexes and the exp2 table
// generator used at elaboration.
// ----------------------------------------------------------------------------
package rbfk_pkg;

    // Number of coordinate slots carried in one request
    localparam int unsigned COORDS      = 4;
    localparam int unsigned COORD_W     = 16;
    localparam int unsigned PARAM_W     = 16;
    localparam int unsigned DIMS_W      = 3;
    localparam int unsigned KERNEL_W    = 32;
    localparam int unsigned CFG_INDEX_W = 3;

    // log2(e) in Q.16 and ln(2) in Q.30
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam longint unsigned LN2_Q30 = 64'd744261118;

    // Series length of the table generator
    localparam int unsigned SERIES_TERMS = 24;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_AMPLITUDE    = 3'd0,
        REG_NOISE_TERM   = 3'd1,
        REG_WEIGHT_ZERO  = 3'd2,
        REG_WEIGHT_ONE   = 3'd3,
        REG_WEIGHT_TWO   = 3'd4,
        REG_WEIGHT_THREE = 3'd5,
        REG_ACTIVE_DIMS  = 3'd6
    } cfg_reg_t;

    // Unsigned floor quotient by shift and subtract; constant arguments only
    function automatic longint unsigned const_udiv(input longint unsigned num,
                                                   input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int bit_pos = 63; bit_pos >= 0; bit_pos--)
        begin
            rem = {rem[62:0], num[bit_pos]};
            if (rem >= den)
            begin
                rem          = rem - den;
                quo[bit_pos] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Table entry round(2^16 * 2^(-i / 2^bits)) from a Taylor series of
    // exp(-t); evaluated with constant arguments only.
    function automatic longint unsigned exp2_entry(input int unsigned bits,
                                                   input int unsigned i);
        longint unsigned t;
        longint unsigned term;
        longint unsigned sum;
        t    = (longint'(i) * LN2_Q30) >> bits;
        term = 64'd1 << 30;
        sum  = 64'd1 << 30;
        for (int unsigned k = 1; k <= SERIES_TERMS; k++)
        begin
            term = const_udiv((term * t) >> 30, 64'(k));
            if (k[0])
                sum = sum - term;
            else
                sum = sum + term;
        end
        return (sum + 64'd8192) >> 14;
    endfunction

endpackage

// ----- sv/rbf_kernel_entry_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbf_kernel_entry_unit - squared-exponential ARD kernel entry
// Computes amplitude * exp(-0.5 * sum_d w_d (a_d - b_d)^2), plus the noise
// term on diagonal entries, as unsigned Q16.16 with saturation flag.
//
// Usage:
//  - s_axis carries one point pair per request; tuser is the diagonal flag.
//  - m_axis returns one kernel entry per request, in order; tuser flags a
//    clipped result.
//  - cfg writes one register per request (index 0..6); cfg_ready is always
//    high. Write only while the pipeline is empty.
//  - Each entry moves through the stages in order; the first stage loads at
//    the accepting edge and the last stage is the output register that
//    presents the entry on m_axis.
//  - Throughput is one request per cycle while the output is taken; ten
//    register stages, each with a valid bit, hold the difference, square,
//    weighting, distance sum, log2(e) scaling (two partial products), exponent
//    split, exp2 table read, shift, amplitude product and output rounding.
//  - When m_axis_tready is low, only full stages hold; bubbles still close
//    up, so input keeps flowing until every stage is occupied.
//  - Reset clears all valid bits and loads the register defaults (amplitude
//    1.0, noise 0, weights 1.0, four active dimensions).
// ----------------------------------------------------------------------------
module rbf_kernel_entry_unit
    import rbfk_pkg::*;
#(
    parameter int unsigned MAX_DIMS       = 4,
    parameter int unsigned EXP_TABLE_BITS = 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // config write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [PARAM_W-1:0]        cfg_data,
    // input stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // [15:0] point_a_c0, [31:16] point_a_c1, [47:32] point_a_c2,
    // [63:48] point_a_c3, [79:64] point_b_c0, [95:80] point_b_c1,
    // [111:96] point_b_c2, [127:112] point_b_c3
    input  logic [2*COORDS*COORD_W-1:0] s_axis_tdata,
    // [0] add_noise
    input  logic                      s_axis_tuser,
    // output stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [31:0] kernel_value
    output logic [KERNEL_W-1:0]       m_axis_tdata,
    // [0] saturated
    output logic                      m_axis_tuser
);

    localparam int unsigned NUM_STAGES = 10;
    localparam int unsigned LAST       = NUM_STAGES - 1;
    localparam int unsigned TABLE_SIZE = 1 << EXP_TABLE_BITS;
    localparam int unsigned DIFF_W     = COORD_W + 1;
    localparam int unsigned SQ_W       = 2 * COORD_W;
    localparam int unsigned PROD_W     = SQ_W + PARAM_W;
    localparam int unsigned DIST_W     = PROD_W + 2;
    localparam int unsigned FAR_BIT    = 38;
    localparam int unsigned SPLIT      = FAR_BIT / 2;
    localparam int unsigned PART_W     = SPLIT + 17;
    localparam int unsigned Y_W        = FAR_BIT + 17;
    localparam int unsigned Y_FRAC     = 49;
    localparam int unsigned E_W        = 17;
    localparam int unsigned SHIFT_W    = 5;
    localparam int unsigned AMP_W      = PARAM_W + E_W;
    localparam int unsigned TOTAL_W    = AMP_W + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [PARAM_W-1:0] amplitude_reg;
    logic [PARAM_W-1:0] noise_term_reg;
    logic [PARAM_W-1:0] weight_reg [COORDS];
    logic [DIMS_W-1:0]  active_dims_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amplitude_reg   <= 16'd256;
            noise_term_reg  <= '0;
            for (int d = 0; d < COORDS; d++)
                weight_reg[d] <= 16'd256;
            active_dims_reg <= 3'd4;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_AMPLITUDE:    amplitude_reg   <= cfg_data;
                REG_NOISE_TERM:   noise_term_reg  <= cfg_data;
                REG_WEIGHT_ZERO:  weight_reg[0]   <= cfg_data;
                REG_WEIGHT_ONE:   weight_reg[1]   <= cfg_data;
                REG_WEIGHT_TWO:   weight_reg[2]   <= cfg_data;
                REG_WEIGHT_THREE: weight_reg[3]   <= cfg_data;
                REG_ACTIVE_DIMS:  active_dims_reg <= cfg_data[DIMS_W-1:0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage may load when empty or when it drains
    // ------------------------------------------------------------------
    logic valid_reg   [NUM_STAGES];
    logic stage_ready [NUM_STAGES];
    logic noise_reg   [NUM_STAGES];

    always_comb
    begin
        stage_ready[LAST] = !valid_reg[LAST] || m_axis_tready;
        for (int i = LAST - 1; i >= 0; i--)
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
    end

    assign s_axis_tready = stage_ready[0];
    assign m_axis_tvalid = valid_reg[LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STAGES; i++)
                valid_reg[i] <= 1'b0;
        end
        else
        begin
            if (stage_ready[0])
                valid_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < NUM_STAGES; i++)
                if (stage_ready[i])
                    valid_reg[i] <= valid_reg[i-1];
        end
    end

    // diagonal flag travels alongside the data
    always_ff @(posedge clk)
    begin
        if (stage_ready[0])
            noise_reg[0] <= s_axis_tuser;
        for (int i = 1; i < NUM_STAGES; i++)
            if (stage_ready[i])
                noise_reg[i] <= noise_reg[i-1];
    end

    // ------------------------------------------------------------------
    // Stages 0..2: per-dimension difference, square, weighting
    // ------------------------------------------------------------------
    logic signed [DIFF_W-1:0] diff_reg [COORDS];
    logic        [SQ_W-1:0]   sq_reg   [COORDS];
    logic        [PROD_W-1:0] prod_reg [COORDS];

    for (genvar d = 0; d < COORDS; d++)
    begin : g_dim
        logic signed [COORD_W-1:0] coord_a;
        logic signed [COORD_W-1:0] coord_b;
        logic signed [DIFF_W-1:0]  diff_next;
        logic signed [2*DIFF_W-1:0] sq_full;
        logic                      dim_on;

        assign coord_a   = s_axis_tdata[d*COORD_W +: COORD_W];
        assign coord_b   = s_axis_tdata[(COORDS+d)*COORD_W +: COORD_W];
        // dimensions beyond the active count or the build limit are dropped
        assign dim_on    = (d < MAX_DIMS) && (DIMS_W'(d) < active_dims_reg);
        assign diff_next = dim_on ? (DIFF_W'(coord_a) - DIFF_W'(coord_b)) : '0;
        assign sq_full   = diff_reg[d] * diff_reg[d];

        always_ff @(posedge clk)
        begin
            if (stage_ready[0])
                diff_reg[d] <= diff_next;
            if (stage_ready[1])
                sq_reg[d]   <= sq_full[SQ_W-1:0];
            if (stage_ready[2])
                prod_reg[d] <= weight_reg[d] * sq_reg[d];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: weighted distance
    // ------------------------------------------------------------------
    logic [DIST_W-1:0] dist_reg;

    always_ff @(posedge clk)
    begin
        if (stage_ready[3])
            dist_reg <= (DIST_W'(prod_reg[0]) + DIST_W'(prod_reg[1]))
                      + (DIST_W'(prod_reg[2]) + DIST_W'(prod_reg[3]));
    end

    // ------------------------------------------------------------------
    // Stage 4: dist * log2(e) as two partial products
    // ------------------------------------------------------------------
    logic [PART_W-1:0] part_lo_reg;
    logic [PART_W-1:0] part_hi_reg;
    logic              far4_reg;

    always_ff @(posedge clk)
    begin
        if (stage_ready[4])
        begin
            part_lo_reg <= dist_reg[SPLIT-1:0] * LOG2E_Q16;
            part_hi_reg <= dist_reg[FAR_BIT-1:SPLIT] * LOG2E_Q16;
            far4_reg    <= |dist_reg[DIST_W-1:FAR_BIT];
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: exponent split into shift and table index
    // ------------------------------------------------------------------
    logic [Y_W-1:0]            y_sum;
    logic [Y_W-Y_FRAC-1:0]     y_int;
    logic [EXP_TABLE_BITS-1:0] idx_reg;
    logic [SHIFT_W-1:0]        shift5_reg;
    logic                      zero5_reg;

    assign y_sum = {part_hi_reg, {SPLIT{1'b0}}} + Y_W'(part_lo_reg);
    assign y_int = y_sum[Y_W-1:Y_FRAC];

    always_ff @(posedge clk)
    begin
        if (stage_ready[5])
        begin
            idx_reg    <= y_sum[Y_FRAC-1 -: EXP_TABLE_BITS];
            shift5_reg <= y_int[SHIFT_W-1:0];
            zero5_reg  <= far4_reg || (y_int >= (Y_W-Y_FRAC)'(17));
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: exp2 fraction table read
    // ------------------------------------------------------------------
    logic [E_W-1:0]     exp_rom [TABLE_SIZE];
    logic [E_W-1:0]     rom_reg;
    logic [SHIFT_W-1:0] shift6_reg;
    logic               zero6_reg;

    for (genvar t = 0; t < TABLE_SIZE; t++)
    begin : g_rom
        assign exp_rom[t] = E_W'(exp2_entry(EXP_TABLE_BITS, t));
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[6])
        begin
            rom_reg    <= exp_rom[idx_reg];
            shift6_reg <= shift5_reg;
            zero6_reg  <= zero5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: integer part of the exponent as a right shift
    // ------------------------------------------------------------------
    logic [E_W-1:0] e_reg;

    always_ff @(posedge clk)
    begin
        if (stage_ready[7])
            e_reg <= zero6_reg ? '0 : (rom_reg >> shift6_reg);
    end

    // ------------------------------------------------------------------
    // Stage 8: amplitude scaling
    // ------------------------------------------------------------------
    logic [AMP_W-1:0] amp_prod_reg;

    always_ff @(posedge clk)
    begin
        if (stage_ready[8])
            amp_prod_reg <= amplitude_reg * e_reg;
    end

    // ------------------------------------------------------------------
    // Stage 9: rounding, noise term, saturation, output register
    // ------------------------------------------------------------------
    logic [TOTAL_W-1:0]  rounded;
    logic [TOTAL_W-1:0]  noise_add;
    logic [TOTAL_W+1:0]  total;
    logic [KERNEL_W-1:0] out_data_reg;
    logic                out_sat_reg;
    logic                over;

    assign rounded   = (TOTAL_W'(amp_prod_reg) + TOTAL_W'(128)) >> 8;
    assign noise_add = noise_reg[8] ? TOTAL_W'({noise_term_reg, 8'd0}) : '0;
    assign total     = (TOTAL_W+2)'(rounded) + (TOTAL_W+2)'(noise_add);
    assign over      = |total[TOTAL_W+1:KERNEL_W];

    always_ff @(posedge clk)
    begin
        if (stage_ready[9])
        begin
            out_data_reg <= over ? '1 : total[KERNEL_W-1:0];
            out_sat_reg  <= over;
        end
    end

    assign m_axis_tdata = out_data_reg;
    assign m_axis_tuser = out_sat_reg;

endmodule
